// ===== hw/rtl/dpes_pkg.sv =====
`default_nettype none
package dpes_pkg;

  localparam int NODE_W = 10;
  localparam int EIDX_W = 12;
  localparam int REQ_W = 2;
  localparam int STAT_W = 3;
  localparam int CNT_W = 32;
  localparam int IN_TDATA_W = 48;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_SWAP = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_REJECT  = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_BADIDX  = 3'd3,
    STAT_MISSING = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_LD_DEG_A,
    ST_LD_DEG_B,
    ST_LD_CHECK,
    ST_LD_WR_A,
    ST_LD_WR_B,
    ST_RD_ISSUE,
    ST_RD_CAPTURE,
    ST_SW_RD_R,
    ST_SW_RD_S,
    ST_SW_CHECK,
    ST_SW_DEG,
    ST_SW_DEG_CAP,
    ST_SW_SCAN,
    ST_SW_WR0,
    ST_SW_WR1,
    ST_SW_WR2,
    ST_SW_WR3,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dpes_ram.sv =====
`default_nettype none
module dpes_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/degree_preserving_edge_swap_core.sv =====
`default_nettype none
// channel  direction  beat contents
// s_*      in         request: tuser req_type, tdata edge indexes and load nodes
// m_*      out        result: tuser status, tdata nodes, swap count, target flag
// apb      in/out     swap_target register at byte address 0
//
// one request at a time; the run time of a swap is set by the neighbour list
// scans through the single port of the neighbour memory
// after rst a clearing pass writes zero degrees to every node; no beat taken
// a waiting result sits in the output register while the next request enters
module degree_preserving_edge_swap_core #(
  parameter int NODES = 1024,
  parameter int EDGES = 4096,
  parameter int MAX_DEGREE = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // edge_first, edge_second, node_from, node_to, zero pad
  input  wire logic [dpes_pkg::IN_TDATA_W-1:0]    s_tdata,
  // req_type
  input  wire logic [dpes_pkg::REQ_W-1:0]         s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // src_node, dst_node, accepted_count, target_reached, zero pad
  output logic      [dpes_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // status
  output logic      [dpes_pkg::STAT_W-1:0]        m_tuser,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready
);
  import dpes_pkg::*;

  localparam int NAW = $clog2(NODES);
  localparam int EAW = $clog2(EDGES);
  localparam int LW  = $clog2(EDGES + 1);
  localparam int DW  = $clog2(MAX_DEGREE + 1);
  localparam int NBW = $clog2(NODES * MAX_DEGREE);

  state_t state, state_next;

  // latched request
  logic [REQ_W-1:0]  rq_type;
  logic [EIDX_W-1:0] ef, es;
  logic [NODE_W-1:0] nf, nt;

  logic [LW-1:0]     loaded;
  logic [CNT_W-1:0]  swaps;
  logic [31:0]       target;
  logic [NAW-1:0]    clr_ptr;

  // swap edge endpoints
  logic [NODE_W-1:0] r1, r2, s1, s2;
  logic [DW-1:0]     deg_a, deg_b;

  // scan control
  logic [2:0]        k;
  logic [DW-1:0]     j, pj;
  logic              pend;
  logic [DW-1:0]     pos [4];

  // pending result
  status_t           res_status;
  logic [NODE_W-1:0] res_src, res_dst;

  // memory ports
  logic                  e_we;
  logic [EAW-1:0]        e_addr;
  logic [2*NODE_W-1:0]   e_wdata, e_rdata;
  logic                  d_we;
  logic [NAW-1:0]        d_addr;
  logic [DW-1:0]         d_wdata, d_rdata;
  logic                  n_we;
  logic [NBW-1:0]        n_addr;
  logic [NODE_W-1:0]     n_wdata, n_rdata;

  dpes_ram #(.WIDTH(2 * NODE_W), .DEPTH(EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
  );

  dpes_ram #(.WIDTH(DW), .DEPTH(NODES)) u_deg_ram (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
  );

  dpes_ram #(.WIDTH(NODE_W), .DEPTH(NODES * MAX_DEGREE)) u_nbr_ram (
    .clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata)
  );

  function automatic logic [NBW-1:0] nb_addr(input logic [NODE_W-1:0] node,
                                             input logic [DW-1:0] slot);
    return NBW'(NAW'(node)) * NBW'(MAX_DEGREE) + NBW'(slot);
  endfunction

  // the six scans: two adjacency checks, then the four back entries
  logic [NODE_W-1:0] sc_owner, sc_who;
  always_comb begin
    case (k)
      3'd0:    begin sc_owner = s1; sc_who = r2; end
      3'd1:    begin sc_owner = r1; sc_who = s2; end
      3'd2:    begin sc_owner = r2; sc_who = r1; end
      3'd3:    begin sc_owner = s2; sc_who = s1; end
      3'd4:    begin sc_owner = r1; sc_who = r2; end
      default: begin sc_owner = s1; sc_who = s2; end
    endcase
  end

  logic sc_hit, sc_more;
  assign sc_hit  = pend && (n_rdata == sc_who);
  assign sc_more = 32'(j) < 32'(deg_a);

  logic nodes_bad, self_loop, room, req_sw_ok;
  logic [DW-1:0] deg_b_eff;
  assign nodes_bad = (32'(nf) >= NODES) || (32'(nt) >= NODES);
  assign self_loop = (nf == nt);
  assign room = self_loop ? (32'(deg_a) + 32'd2 <= MAX_DEGREE)
                          : ((32'(deg_a) < MAX_DEGREE) && (32'(d_rdata) < MAX_DEGREE));
  assign deg_b_eff = self_loop ? deg_a + DW'(1) : deg_b;
  assign req_sw_ok = (32'(ef) < 32'(loaded)) && (32'(es) < 32'(loaded));

  logic shared;
  assign shared = (e_rdata[NODE_W-1:0] == r1) || (e_rdata[NODE_W-1:0] == r2) ||
                  (e_rdata[2*NODE_W-1:NODE_W] == r1) ||
                  (e_rdata[2*NODE_W-1:NODE_W] == r2) || (r1 == r2) ||
                  (e_rdata[NODE_W-1:0] == e_rdata[2*NODE_W-1:NODE_W]);

  logic out_load;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    e_we = 1'b0; e_addr = EAW'(ef); e_wdata = '0;
    d_we = 1'b0; d_addr = NAW'(nf); d_wdata = '0;
    n_we = 1'b0; n_addr = nb_addr(sc_owner, j); n_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        d_we = 1'b1; d_addr = clr_ptr;
        if (32'(clr_ptr) == NODES - 1) state_next = ST_IDLE;
      end
      ST_IDLE: if (s_tvalid) state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (rq_type)
          REQ_LOAD: state_next = (nodes_bad || 32'(loaded) >= EDGES) ? ST_DONE
                                                                     : ST_LD_DEG_A;
          REQ_READ: state_next = (32'(ef) < 32'(loaded)) ? ST_RD_ISSUE : ST_DONE;
          REQ_SWAP: state_next = req_sw_ok ? ST_SW_RD_R : ST_DONE;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_LD_DEG_A: begin d_addr = NAW'(nf); state_next = ST_LD_DEG_B; end
      ST_LD_DEG_B: begin d_addr = NAW'(nt); state_next = ST_LD_CHECK; end
      ST_LD_CHECK: state_next = room ? ST_LD_WR_A : ST_DONE;
      ST_LD_WR_A: begin
        e_we = 1'b1; e_addr = EAW'(loaded); e_wdata = {nt, nf};
        n_we = 1'b1; n_addr = nb_addr(nf, deg_a); n_wdata = nt;
        d_we = 1'b1; d_addr = NAW'(nf); d_wdata = deg_a + DW'(1);
        state_next = ST_LD_WR_B;
      end
      ST_LD_WR_B: begin
        n_we = 1'b1; n_addr = nb_addr(nt, deg_b_eff); n_wdata = nf;
        d_we = 1'b1; d_addr = NAW'(nt); d_wdata = deg_b_eff + DW'(1);
        state_next = ST_DONE;
      end
      ST_RD_ISSUE:   begin e_addr = EAW'(ef); state_next = ST_RD_CAPTURE; end
      ST_RD_CAPTURE: state_next = ST_DONE;
      ST_SW_RD_R:    begin e_addr = EAW'(ef); state_next = ST_SW_RD_S; end
      ST_SW_RD_S:    begin e_addr = EAW'(es); state_next = ST_SW_CHECK; end
      ST_SW_CHECK:   state_next = shared ? ST_DONE : ST_SW_DEG;
      ST_SW_DEG:     begin d_addr = NAW'(sc_owner); state_next = ST_SW_DEG_CAP; end
      ST_SW_DEG_CAP: state_next = ST_SW_SCAN;
      ST_SW_SCAN: begin
        n_addr = nb_addr(sc_owner, j);
        if (sc_hit) begin
          if (k <= 3'd1) state_next = ST_DONE;
          else if (k == 3'd5) state_next = ST_SW_WR0;
          else state_next = ST_SW_DEG;
        end else if (!sc_more) begin
          state_next = (k <= 3'd1) ? ST_SW_DEG : ST_DONE;
        end
      end
      ST_SW_WR0: begin
        n_we = 1'b1; n_addr = nb_addr(r1, pos[2]); n_wdata = s2;
        e_we = 1'b1; e_addr = EAW'(ef); e_wdata = {s2, r1};
        state_next = ST_SW_WR1;
      end
      ST_SW_WR1: begin
        n_we = 1'b1; n_addr = nb_addr(r2, pos[0]); n_wdata = s1;
        e_we = 1'b1; e_addr = EAW'(es); e_wdata = {r2, s1};
        state_next = ST_SW_WR2;
      end
      ST_SW_WR2: begin
        n_we = 1'b1; n_addr = nb_addr(s1, pos[3]); n_wdata = r2;
        state_next = ST_SW_WR3;
      end
      ST_SW_WR3: begin
        n_we = 1'b1; n_addr = nb_addr(s2, pos[1]); n_wdata = r1;
        state_next = ST_DONE;
      end
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
      loaded  <= '0;
      swaps   <= '0;
      target  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_ptr <= clr_ptr + NAW'(1);
      if (state == ST_LD_WR_B) loaded <= loaded + LW'(1);
      if (state == ST_SW_WR3 && swaps != '1) swaps <= swaps + CNT_W'(1);
      if (psel && penable && pwrite && !paddr[2]) target <= pwdata;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      rq_type <= s_tuser;
      ef <= s_tdata[11:0];
      es <= s_tdata[23:12];
      nf <= s_tdata[33:24];
      nt <= s_tdata[43:34];
    end
    case (state)
      ST_DECODE: begin
        res_status <= (rq_type == REQ_LOAD && !nodes_bad) ? STAT_FULL : STAT_BADIDX;
        res_src <= '0; res_dst <= '0;
      end
      ST_LD_DEG_B: deg_a <= d_rdata;
      ST_LD_CHECK: deg_b <= d_rdata;
      ST_LD_WR_B: begin res_status <= STAT_OK; res_src <= nf; res_dst <= nt; end
      ST_RD_CAPTURE: begin
        res_status <= STAT_OK;
        res_src <= e_rdata[NODE_W-1:0];
        res_dst <= e_rdata[2*NODE_W-1:NODE_W];
      end
      ST_SW_RD_S: begin
        r1 <= e_rdata[NODE_W-1:0];
        r2 <= e_rdata[2*NODE_W-1:NODE_W];
      end
      ST_SW_CHECK: begin
        s1 <= e_rdata[NODE_W-1:0];
        s2 <= e_rdata[2*NODE_W-1:NODE_W];
        res_src <= r1; res_dst <= r2;
        res_status <= STAT_REJECT;
        k <= 3'd0;
      end
      ST_SW_DEG_CAP: begin deg_a <= d_rdata; j <= '0; pend <= 1'b0; end
      ST_SW_SCAN: begin
        if (sc_hit) begin
          if (k >= 3'd2) pos[k[1:0] - 2'd2] <= pj;
          k <= k + 3'd1;
        end else if (sc_more) begin
          pend <= 1'b1; pj <= j; j <= j + DW'(1);
        end else begin
          if (k >= 3'd2) res_status <= STAT_MISSING;
          k <= k + 3'd1;
        end
      end
      ST_SW_WR3: begin res_status <= STAT_OK; res_dst <= s2; end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {3'b000,
                  (state == ST_DONE) && (swaps >= target),
                  swaps, res_dst, res_src};
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : target;

endmodule
`default_nettype wire
